// ===== hw/rtl/sample_voice_player_core_macros.svh =====
// Assertion macros for the voice player checker.
`ifndef SAMPLE_VOICE_PLAYER_CORE_MACROS_SVH
`define SAMPLE_VOICE_PLAYER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SVP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice player check failed");

// Next-cycle implication, held off during reset.
`define SVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice player check failed");

`endif

// ===== hw/rtl/svp_pkg.sv =====
`default_nettype none
package svp_pkg;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_TRIGGER = 2'd1;
   localparam logic [1:0] FUNC_STOP    = 2'd2;
   localparam logic [1:0] FUNC_TICK    = 2'd3;

   localparam logic [1:0] CSR_SAMPLE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_LOOP_START    = 2'd1;
   localparam logic [1:0] CSR_LOOP_LENGTH   = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_RATE   = 2'd3;

   localparam int          NOTE_COUNT = 36;
   localparam int          NUM_BASE   = 35468946;   // clock constant times ten
   localparam int          NUM_W      = 26;
   localparam int          PER_W      = 14;
   localparam int          RATE_W     = 17;
   localparam int          DEN_W      = PER_W + RATE_W;
   localparam logic [16:0] RATE_RESET = 17'd22050;

   typedef struct packed {
      logic capture;
      logic load_we;
      logic stop;
      logic trig_mul;
      logic div_init;
      logic div_step;
      logic trig_commit;
      logic tick_addr;
      logic tick_d0;
      logic tick_interp;
      logic tick_scale;
      logic tick_wrap;
      logic clear_res;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       note_ok;
      logic       playing;
      logic       tick_ok;
      logic       div_last;
   } ctl_status_type;

   // ten times the period of each note
   function automatic logic [PER_W-1:0] period_x10(input logic [5:0] note);
      logic [PER_W-1:0] p;
      case (note)
         6'd0:  p = 14'd8560;  6'd1:  p = 14'd8080;  6'd2:  p = 14'd7620;
         6'd3:  p = 14'd7200;  6'd4:  p = 14'd6780;  6'd5:  p = 14'd6400;
         6'd6:  p = 14'd6040;  6'd7:  p = 14'd5700;  6'd8:  p = 14'd5380;
         6'd9:  p = 14'd5080;  6'd10: p = 14'd4800;  6'd11: p = 14'd4530;
         6'd12: p = 14'd4280;  6'd13: p = 14'd4040;  6'd14: p = 14'd3810;
         6'd15: p = 14'd3600;  6'd16: p = 14'd3390;  6'd17: p = 14'd3200;
         6'd18: p = 14'd3020;  6'd19: p = 14'd2850;  6'd20: p = 14'd2690;
         6'd21: p = 14'd2540;  6'd22: p = 14'd2400;  6'd23: p = 14'd2260;
         6'd24: p = 14'd2140;  6'd25: p = 14'd2020;  6'd26: p = 14'd1900;
         6'd27: p = 14'd1800;  6'd28: p = 14'd1700;  6'd29: p = 14'd1600;
         6'd30: p = 14'd1510;  6'd31: p = 14'd1430;  6'd32: p = 14'd1350;
         6'd33: p = 14'd1270;  6'd34: p = 14'd1200;  6'd35: p = 14'd1130;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/svp_ctrl.sv =====
`default_nettype none
module svp_ctrl
   import svp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output      logic           req_tready,
   output      logic           rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire ctl_status_type status,
   output      ctl_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_TRIG_MUL = 4'd2;
   localparam logic [3:0] S_DIV_INIT = 4'd3;
   localparam logic [3:0] S_DIV      = 4'd4;
   localparam logic [3:0] S_TRIG_END = 4'd5;
   localparam logic [3:0] S_ADDR     = 4'd6;
   localparam logic [3:0] S_RD1      = 4'd7;
   localparam logic [3:0] S_INTERP   = 4'd8;
   localparam logic [3:0] S_SCALE    = 4'd9;
   localparam logic [3:0] S_WRAP     = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.clear_res = 1'b1;
            state_in      = S_DONE;
            unique case (status.func)
               FUNC_LOAD: cmd.load_we = 1'b1;
               FUNC_TRIGGER: begin
                  if (status.note_ok) state_in = S_TRIG_MUL;
               end
               FUNC_STOP: cmd.stop = 1'b1;
               FUNC_TICK: begin
                  if (status.playing) state_in = S_ADDR;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_TRIG_MUL: begin
            cmd.trig_mul = 1'b1;
            state_in     = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_TRIG_END;
         end
         S_TRIG_END: begin
            cmd.trig_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_ADDR: begin
            cmd.tick_addr = 1'b1;
            state_in      = S_RD1;
         end
         S_RD1: begin
            cmd.tick_d0 = 1'b1;
            state_in    = status.tick_ok ? S_INTERP : S_DONE;
         end
         S_INTERP: begin
            cmd.tick_interp = 1'b1;
            state_in        = S_SCALE;
         end
         S_SCALE: begin
            cmd.tick_scale = 1'b1;
            state_in       = S_WRAP;
         end
         S_WRAP: begin
            cmd.tick_wrap = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/svp_datapath.sv =====
`default_nettype none
module svp_datapath
   import svp_pkg::*;
#(
   parameter int WAVE_DEPTH = 65536,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ctl_cmd_type    cmd,
   output      ctl_status_type status,
   input  wire logic           csr_we,
   input  wire logic [1:0]     csr_index,
   input  wire logic [16:0]    csr_data,
   input  wire logic [1:0]     func,
   input  wire logic [15:0]    sample_addr,
   input  wire logic [7:0]     sample_value,
   input  wire logic [5:0]     note_number,
   input  wire logic [13:0]    note_volume,
   output      logic [7:0]     sample_out,
   output      logic           voice_active,
   output      logic           note_ended
);

   localparam int F   = FRAC_BITS;
   localparam int AW  = $clog2(WAVE_DEPTH);
   localparam int PW  = ((17 + F) > 32 ? (17 + F) : 32) + 1;
   localparam int IW  = PW - F;
   localparam int XW  = IW + 2;
   localparam int NW  = NUM_W + F + 1;
   localparam int CW  = $clog2(NW);
   localparam int IPW = F + 10;
   localparam int MW  = F + 21;
   localparam int SW  = MW + 8;

   // configuration
   logic [16:0] sample_length_ff, loop_start_ff_x, loop_length_ff, output_rate_ff;
   logic [15:0] loop_start_ff;

   // captured item
   logic [1:0]  func_ff;
   logic [15:0] addr_ff;
   logic [7:0]  value_ff;
   logic [5:0]  note_ff;
   logic [13:0] vol_ff;

   // voice state
   logic [PW-1:0] phase_ff;
   logic [31:0]   step_ff;
   logic [13:0]   level_ff;
   logic          playing_ff;

   // memory
   logic signed [7:0] mem [WAVE_DEPTH];
   logic signed [7:0] rd_ff;
   logic [AW-1:0]     rd_addr;

   // step divider
   logic [DEN_W-1:0] den_ff;
   logic [NW-1:0]    dvd_ff, quot_ff;
   logic [DEN_W:0]   rem_ff, rem_sh;
   logic [CW-1:0]    cnt_ff;
   logic [31:0]      step_new;

   // tick path
   logic signed [XW-1:0] x0, x1a, x1, loop_stop_x, len_x;
   logic [17:0]          loop_stop;
   logic                 loop_on, ok0, ok1;
   logic [AW-1:0]        x1_ff;
   logic                 ok_ff;
   logic signed [7:0]    d0_ff;
   logic signed [8:0]    diff;
   logic signed [IPW-1:0] interp, interp_ff;
   logic [PW-1:0]        sum_ff, thr, lenf, slf, wrapped;
   logic [MW-1:0]        prod_ff;
   logic [SW-1:0]        scaled;
   logic [14:0]          top;
   logic [7:0]           res_byte_ff, byte_in;
   logic                 res_end_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_active_ff, out_end_ff;

   assign loop_start_ff_x = {1'b0, loop_start_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_length_ff <= '0;
         loop_start_ff    <= '0;
         loop_length_ff   <= '0;
         output_rate_ff   <= RATE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_LENGTH: sample_length_ff <= csr_data;
            CSR_LOOP_START:    loop_start_ff    <= csr_data[15:0];
            CSR_LOOP_LENGTH:   loop_length_ff   <= csr_data;
            CSR_OUTPUT_RATE:   output_rate_ff   <= csr_data;
            default:           sample_length_ff <= sample_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func;
         addr_ff  <= sample_addr;
         value_ff <= sample_value;
         note_ff  <= note_number;
         vol_ff   <= note_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && (32'(addr_ff) < WAVE_DEPTH)) begin
         mem[AW'(addr_ff)] <= value_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   // step = round(NUM_BASE * 2^F / den) with den = 10 * period * rate
   assign rem_sh = {rem_ff[DEN_W-1:0], dvd_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (cmd.trig_mul) begin
         den_ff <= DEN_W'(period_x10(note_ff) * output_rate_ff);
      end
      if (cmd.div_init) begin
         dvd_ff  <= (NW'(NUM_BASE) << F) + NW'(den_ff >> 1);
         rem_ff  <= '0;
         quot_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[NW-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff  <= rem_sh - {1'b0, den_ff};
            quot_ff <= {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            quot_ff <= {quot_ff[NW-2:0], 1'b0};
         end
      end
   end

   assign step_new = ((den_ff == '0) || (|quot_ff[NW-1:32])) ? 32'hFFFF_FFFF
                                                            : quot_ff[31:0];

   // tick address and range checks
   assign loop_on     = loop_length_ff > 17'd2;
   assign loop_stop   = 18'(loop_start_ff_x) + 18'(loop_length_ff);
   assign loop_stop_x = XW'(loop_stop);
   assign len_x       = XW'(loop_length_ff);
   assign x0          = XW'(phase_ff[PW-1:F]);
   assign x1a         = x0 + XW'(1);
   assign x1          = (loop_on && (x1a >= loop_stop_x)) ? x1a - len_x : x1a;
   assign ok0 = !x0[XW-1] && (x0[XW-2:0] < (XW-1)'(sample_length_ff))
              && (x0[XW-2:0] < (XW-1)'(WAVE_DEPTH));
   assign ok1 = !x1[XW-1] && (x1[XW-2:0] < (XW-1)'(sample_length_ff))
              && (x1[XW-2:0] < (XW-1)'(WAVE_DEPTH));
   assign rd_addr = cmd.tick_addr ? AW'(x0[XW-2:0]) : x1_ff;

   assign diff   = 9'(rd_ff) - 9'(d0_ff);
   assign interp = (IPW'(d0_ff) <<< F)
                 + IPW'($signed({1'b0, phase_ff[F-1:0]}) * diff);

   assign scaled  = {prod_ff, 8'b0} - SW'(prod_ff);
   assign top     = scaled[SW-1:14+F];
   assign byte_in = (|top[14:8]) ? 8'hFF : top[7:0];

   assign thr     = PW'(loop_stop - 18'd1) << F;
   assign lenf    = PW'(loop_length_ff) << F;
   assign slf     = PW'(sample_length_ff) << F;
   assign wrapped = (sum_ff >= lenf) ? sum_ff - lenf : '0;

   always_ff @(posedge clock) begin
      if (cmd.tick_addr) begin
         x1_ff <= AW'(x1[XW-2:0]);
         ok_ff <= ok0 && ok1;
      end
      if (cmd.tick_d0) begin
         d0_ff <= rd_ff;
      end
      if (cmd.tick_interp) begin
         interp_ff <= interp;
         sum_ff    <= phase_ff + PW'(step_ff);
      end
      if (cmd.tick_scale) begin
         prod_ff <= (!interp_ff[IPW-1] && (|interp_ff))
                  ? MW'(interp_ff[F+6:0] * level_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         step_ff    <= '0;
         level_ff   <= '0;
         playing_ff <= 1'b0;
      end else if (cmd.stop) begin
         phase_ff   <= '0;
         step_ff    <= '0;
         level_ff   <= '0;
         playing_ff <= 1'b0;
      end else if (cmd.trig_commit) begin
         phase_ff   <= '0;
         step_ff    <= step_new;
         level_ff   <= vol_ff;
         playing_ff <= 1'b1;
      end else if (cmd.tick_wrap) begin
         if (loop_on) begin
            phase_ff <= (sum_ff >= thr) ? wrapped : sum_ff;
         end else if (sum_ff >= slf) begin
            phase_ff   <= '0;
            step_ff    <= '0;
            level_ff   <= '0;
            playing_ff <= 1'b0;
         end else begin
            phase_ff <= sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_res) begin
         res_byte_ff <= '0;
         res_end_ff  <= 1'b0;
      end else if (cmd.tick_wrap) begin
         res_byte_ff <= byte_in;
         res_end_ff  <= !loop_on && (sum_ff >= slf);
      end
      if (cmd.publish) begin
         out_byte_ff   <= res_byte_ff;
         out_active_ff <= playing_ff;
         out_end_ff    <= res_end_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.note_ok  = note_ff < 6'(NOTE_COUNT);
   assign status.playing  = playing_ff;
   assign status.tick_ok  = ok_ff;
   assign status.div_last = cnt_ff == CW'(NW - 1);

   assign sample_out   = out_byte_ff;
   assign voice_active = out_active_ff;
   assign note_ended   = out_end_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sample_voice_player_core.sv =====
// One wavetable voice playing signed 8-bit samples.
// req channel: one item per transfer; tuser is the function (load, trigger,
// stop, tick), tdata carries address, sample byte, note and volume.
// rsp channel: exactly one result per request, in order: the output byte
// (nonzero only for a tick), plus voice-active and note-ended flags.
// csr channel: register writes, always ready; write only while idle.
// Items are handled one at a time. Load, stop, an idle tick or an invalid
// note pass from capture through decode to the result; a playing tick
// also makes two reads of the single-port sample memory, interpolates,
// scales and advances, or stops early when a read falls outside the sample.
// A trigger waits on the restoring divider that forms the phase step,
// one quotient bit per cycle.
// A new request is taken while a result still waits; if the receiver stalls,
// the next result is held in the engine until the output register frees.
// Reset clears the voice and registers (output_rate 22050); the sample
// memory is not cleared and needs no startup pass.
`default_nettype none
module sample_voice_player_core
   import svp_pkg::*;
#(
   parameter int WAVE_DEPTH = 65536,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,  // sample_addr, sample_value, note_number, note_volume
   input  wire logic [1:0]  req_tuser,  // func
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,  // sample_out
   output      logic [1:0]  rsp_tuser,  // voice_active, note_ended
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           voice_active, note_ended;

   assign csr_ready = 1'b1;

   svp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   svp_datapath #(
      .WAVE_DEPTH (WAVE_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .func         (req_tuser),
      .sample_addr  (req_tdata[15:0]),
      .sample_value (req_tdata[23:16]),
      .note_number  (req_tdata[29:24]),
      .note_volume  (req_tdata[43:30]),
      .sample_out   (rsp_tdata),
      .voice_active (voice_active),
      .note_ended   (note_ended)
   );

   assign rsp_tuser = {note_ended, voice_active};

endmodule
`default_nettype wire

// ===== hw/rtl/svp_checker.sv =====
`default_nettype none
`include "sample_voice_player_core_macros.svh"
module svp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   `SVP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SVP_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `SVP_ASSERT_NOW(a_end_not_active, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0])
   `SVP_ASSERT_NOW(a_sound_needs_note, clock, reset, rsp_tvalid && (rsp_tdata != 8'd0),
      rsp_tuser[0] || rsp_tuser[1])

endmodule

bind sample_voice_player_core svp_checker u_svp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
